// File: hdl/imu_complementary_attitude_filter_top_assert.svh
// ----------------------------------------------------------------------------
// imu complementary attitude filter - assertion macros
// shared property shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define IMUCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMUCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/imucf_pkg.sv
// ----------------------------------------------------------------------------
// imucf_pkg
// types, constants and tables of the imu complementary attitude filter
// ----------------------------------------------------------------------------
package imucf_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_START  = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [0:0] CFG_CALIB_MS = 1'b0;
  localparam logic [0:0] CFG_PERIOD   = 1'b1;

  localparam logic [15:0] CALIB_MS_RESET = 16'd1000;
  localparam logic [16:0] PERIOD_RESET   = 17'd655;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int CORDIC_MAX_ITER       = 32;

  localparam int Q_PI       = 205887;
  localparam int Q_GRAVITY  = 642908;
  localparam int W_GYRO     = 64225;
  localparam int W_ACC      = 1311;
  localparam int ROUND_HALF = 32768;
  localparam int MIN_TARGET = 10;

  // duration/10 as multiply by reciprocal, exact for 16 bit inputs
  localparam int RECIP_TEN   = 52429;
  localparam int RECIP_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;

  // one queued request
  typedef struct packed {
    cmd_e             cmd;
    logic [5:0][31:0] rd;   // ax ay az gx gy gz
  } item_t;

  typedef struct packed {
    logic [15:0] calib_ms;
    logic [16:0] period;
  } cfg_t;

  typedef struct packed {
    logic [5:0][31:0] att;  // roll pitch yaw and the three rates
    logic             calib_result;
    logic             calibrated;
    logic             calibrating;
  } res_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] y;
    logic signed [33:0] x;
  } cordic_req_t;

  typedef struct packed {
    logic               busy;
    logic signed [31:0] z;
  } cordic_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
  } root_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] r;
  } root_rsp_t;

  // arctangent table in q16.16
  function automatic logic signed [31:0] atan_val(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd51472;
      5'd1:    v = 32'sd30386;
      5'd2:    v = 32'sd16055;
      5'd3:    v = 32'sd8150;
      5'd4:    v = 32'sd4091;
      5'd5:    v = 32'sd2047;
      5'd6:    v = 32'sd1024;
      5'd7:    v = 32'sd512;
      5'd8:    v = 32'sd256;
      5'd9:    v = 32'sd128;
      5'd10:   v = 32'sd64;
      5'd11:   v = 32'sd32;
      5'd12:   v = 32'sd16;
      5'd13:   v = 32'sd8;
      5'd14:   v = 32'sd4;
      5'd15:   v = 32'sd2;
      5'd16:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/imucf_front.sv
// ----------------------------------------------------------------------------
// imucf_front
// input stage: takes requests, decodes the command and queues them
// ----------------------------------------------------------------------------
module imucf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [5:0][31:0]    rd_i,
  output logic                item_valid_o,
  output imucf_pkg::item_t    item_o,
  input  logic                item_pop_i
);

  localparam int PW = $clog2(imucf_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(imucf_pkg::QUEUE_DEPTH + 1);

  imucf_pkg::item_t mem_q [imucf_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign in_ready_o   = (cnt_q != CW'(imucf_pkg::QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(imucf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(imucf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // queue storage with decoded command
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].cmd <= imucf_pkg::cmd_e'(command_i);
      mem_q[wr_q].rd  <= rd_i;
    end
  end

endmodule

// File: hdl/imucf_cordic.sv
// ----------------------------------------------------------------------------
// imucf_cordic
// iterative cordic vectoring unit, one micro-rotation per cycle, gives atan2
// ----------------------------------------------------------------------------
module imucf_cordic #(
  parameter int CORDIC_ITERATIONS = imucf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  imucf_pkg::cordic_req_t req_i,
  output imucf_pkg::cordic_rsp_t rsp_o
);

  localparam int ITER = (CORDIC_ITERATIONS > imucf_pkg::CORDIC_MAX_ITER) ?
                        imucf_pkg::CORDIC_MAX_ITER : CORDIC_ITERATIONS;
  localparam int CW = $clog2(ITER + 1);
  localparam int W  = 40;

  logic signed [W-1:0]  x_q, y_q, x_in, y_in, dx, dy;
  logic signed [31:0]   z_q, tab;
  logic [CW-1:0]        i_q;
  logic                 busy_q;

  assign x_in = W'(req_i.x);
  assign y_in = W'(req_i.y);
  assign dx   = y_q >>> i_q;
  assign dy   = x_q >>> i_q;
  assign tab  = imucf_pkg::atan_val(5'(i_q));

  assign rsp_o.busy = busy_q;
  assign rsp_o.z    = z_q;

  // pre-rotation on start, then micro-rotations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (req_i.start) begin
      i_q <= '0;
      if (y_in == '0) begin
        busy_q <= 1'b0;
        z_q    <= (x_in < 0) ? 32'(imucf_pkg::Q_PI) : 32'sd0;
      end else begin
        busy_q <= 1'b1;
        if (x_in < 0) begin
          x_q <= -x_in;
          y_q <= -y_in;
          z_q <= (y_in > 0) ? 32'(imucf_pkg::Q_PI) : -32'(imucf_pkg::Q_PI);
        end else begin
          x_q <= x_in;
          y_q <= y_in;
          z_q <= 32'sd0;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - tab;
      end
      if (i_q == CW'(ITER - 1)) begin
        busy_q <= 1'b0;
      end else begin
        i_q <= i_q + CW'(1);
      end
    end
  end

endmodule

// File: hdl/imucf_root.sv
// ----------------------------------------------------------------------------
// imucf_root
// bit-pair integer square root of a 64 bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module imucf_root (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imucf_pkg::root_req_t req_i,
  output imucf_pkg::root_rsp_t rsp_o
);

  logic [63:0] n_q, r_q, bit_q;
  logic [64:0] trial;
  logic        take;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};
  assign take  = ({1'b0, n_q} >= trial);

  assign rsp_o.busy = (bit_q != '0);
  assign rsp_o.r    = r_q[31:0];

  // one trial subtraction per cycle, bit walks down by two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
      r_q   <= '0;
      n_q   <= '0;
    end else if (req_i.start) begin
      n_q   <= req_i.n;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (bit_q != '0) begin
      if (take) begin
        n_q <= n_q - trial[63:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// File: hdl/imucf_back.sv
// ----------------------------------------------------------------------------
// imucf_back
// execution sequencer: calibration, bias division and the attitude update
// ----------------------------------------------------------------------------
module imucf_back #(
  parameter int CORDIC_ITERATIONS = imucf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  imucf_pkg::item_t  item_i,
  output logic              item_pop_o,
  input  imucf_pkg::cfg_t   cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imucf_pkg::res_t   res_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORR, ST_MUL, ST_ROOT, ST_ROOT_WAIT, ST_PITCH, ST_PITCH_WAIT,
    ST_BLEND, ST_FIN, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_STORE
  } state_e;

  state_e             st_q;
  logic signed [31:0] v_q [6];
  logic signed [31:0] c_q [6];
  logic signed [31:0] off_q [6];
  logic signed [47:0] acc_q [6];
  logic signed [31:0] att_q [6];
  logic [12:0]        cnt_q, tgt_q;
  logic               cal_ing_q, cal_ed_q, calres_q, out_valid_q;
  logic [63:0]        sq1_q, sq2_q;
  logic signed [49:0] gp_q [3];
  logic signed [34:0] rg_q, pg_q, yg_q;
  logic signed [31:0] roll_a_q, pitch_a_q;
  logic signed [51:0] bg_q [2];
  logic signed [43:0] ba_q [2];
  logic [2:0]         k_q;
  logic [47:0]        dvd_q;
  logic [12:0]        rem_q;
  logic [5:0]         dcnt_q;
  logic               neg_q;

  imucf_pkg::cordic_req_t cor_req;
  imucf_pkg::cordic_rsp_t cor_rsp;
  imucf_pkg::root_req_t   root_req;
  imucf_pkg::root_rsp_t   root_rsp;

  logic signed [31:0] corr [6];
  logic [31:0]        tmul;
  logic [12:0]        tgt_calc, cnt_inc;
  logic signed [63:0] c1w, c2w;
  logic signed [49:0] dt_w;
  logic [13:0]        rem2;
  logic               qbit;
  logic signed [32:0] avg;
  logic signed [31:0] off_new;
  logic signed [52:0] bs0, bs1;
  logic [47:0]        acc_mag;

  imucf_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  imucf_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  // bias correction of the held readings
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      corr[j] = imucf_pkg::sat32(64'(v_q[j]) + 64'(off_q[j]));
    end
  end

  // target sample count, duration/10 clamped below
  always_comb begin
    tmul     = 32'(cfg_i.calib_ms) * 32'(imucf_pkg::RECIP_TEN);
    tgt_calc = 13'(tmul >> imucf_pkg::RECIP_SHIFT);
    if (tgt_calc < 13'(imucf_pkg::MIN_TARGET)) begin
      tgt_calc = 13'(imucf_pkg::MIN_TARGET);
    end
    cnt_inc = cnt_q + 13'd1;
  end

  // multiplier operands
  assign c1w  = 64'(c_q[1]);
  assign c2w  = 64'(c_q[2]);
  assign dt_w = 50'($signed({1'b0, cfg_i.period}));

  // restoring divider step and offset from the quotient
  always_comb begin
    acc_mag = acc_q[k_q][47] ? 48'(-acc_q[k_q]) : 48'(acc_q[k_q]);
    rem2    = {rem_q, dvd_q[47]};
    qbit    = (rem2 >= {1'b0, cnt_q});
    avg     = neg_q ? -$signed({1'b0, dvd_q[31:0]}) : $signed({1'b0, dvd_q[31:0]});
    if (k_q == 3'd2) begin
      off_new = imucf_pkg::sat32(64'(imucf_pkg::Q_GRAVITY) - 64'(avg));
    end else begin
      off_new = imucf_pkg::sat32(-64'(avg));
    end
  end

  // blend sums with rounding
  assign bs0 = 53'(bg_q[0]) + 53'(ba_q[0]) + 53'(imucf_pkg::ROUND_HALF);
  assign bs1 = 53'(bg_q[1]) + 53'(ba_q[1]) + 53'(imucf_pkg::ROUND_HALF);

  // unit requests
  always_comb begin
    cor_req.start  = (st_q == ST_ROOT) || (st_q == ST_PITCH);
    root_req.start = (st_q == ST_ROOT);
    root_req.n     = sq1_q + sq2_q;
    if (st_q == ST_PITCH) begin
      cor_req.y = -(34'(c_q[0]));
      cor_req.x = $signed({2'b00, root_rsp.r});
    end else begin
      cor_req.y = 34'(c_q[1]);
      cor_req.x = 34'(c_q[2]);
    end
  end

  assign item_pop_o  = (st_q == ST_IDLE) && item_valid_i && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      res_o.att[j] = att_q[j];
    end
    res_o.calib_result = calres_q;
    res_o.calibrated   = cal_ed_q;
    res_o.calibrating  = cal_ing_q;
  end

  // sequencer with all filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      tgt_q       <= '0;
      cal_ing_q   <= 1'b0;
      cal_ed_q    <= 1'b0;
      calres_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      dcnt_q      <= '0;
      for (int j = 0; j < 6; j++) begin
        att_q[j] <= '0;
        off_q[j] <= '0;
        acc_q[j] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (item_pop_o) begin
            for (int j = 0; j < 6; j++) begin
              v_q[j] <= $signed(item_i.rd[j]);
            end
            unique case (item_i.cmd)
              imucf_pkg::CMD_UPDATE: begin
                calres_q <= 1'b0;
                st_q     <= ST_CORR;
              end
              imucf_pkg::CMD_SAMPLE: begin
                if (!cal_ing_q) begin
                  calres_q    <= cal_ed_q;
                  out_valid_q <= 1'b1;
                end else begin
                  for (int j = 0; j < 6; j++) begin
                    acc_q[j] <= acc_q[j] + 48'($signed(item_i.rd[j]));
                  end
                  cnt_q <= cnt_inc;
                  if (cnt_inc >= tgt_q && cnt_inc != '0) begin
                    k_q  <= '0;
                    st_q <= ST_DIV_LOAD;
                  end else begin
                    calres_q    <= 1'b0;
                    out_valid_q <= 1'b1;
                  end
                end
              end
              imucf_pkg::CMD_START: begin
                tgt_q     <= tgt_calc;
                cal_ing_q <= 1'b1;
                cal_ed_q  <= 1'b0;
                calres_q  <= 1'b0;
                cnt_q     <= '0;
                for (int j = 0; j < 6; j++) begin
                  acc_q[j] <= '0;
                end
                out_valid_q <= 1'b1;
              end
              imucf_pkg::CMD_RESET: begin
                for (int j = 0; j < 6; j++) begin
                  att_q[j] <= '0;
                end
                calres_q    <= 1'b0;
                out_valid_q <= 1'b1;
              end
              default: begin
                st_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CORR: begin
          for (int j = 0; j < 6; j++) begin
            c_q[j] <= corr[j];
          end
          st_q <= ST_MUL;
        end
        ST_MUL: begin
          sq1_q <= $unsigned(c1w * c1w);
          sq2_q <= $unsigned(c2w * c2w);
          for (int j = 0; j < 3; j++) begin
            gp_q[j] <= 50'(c_q[j+3]) * dt_w;
          end
          st_q <= ST_ROOT;
        end
        ST_ROOT: begin
          rg_q <= 35'(att_q[0]) + 35'(gp_q[0] >>> 16);
          pg_q <= 35'(att_q[1]) + 35'(gp_q[1] >>> 16);
          yg_q <= 35'(att_q[2]) + 35'(gp_q[2] >>> 16);
          st_q <= ST_ROOT_WAIT;
        end
        ST_ROOT_WAIT: begin
          if (!root_rsp.busy && !cor_rsp.busy) begin
            roll_a_q <= cor_rsp.z;
            st_q     <= ST_PITCH;
          end
        end
        ST_PITCH: begin
          st_q <= ST_PITCH_WAIT;
        end
        ST_PITCH_WAIT: begin
          if (!cor_rsp.busy) begin
            pitch_a_q <= cor_rsp.z;
            st_q      <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          bg_q[0] <= 52'(rg_q) * 52'(imucf_pkg::W_GYRO);
          bg_q[1] <= 52'(pg_q) * 52'(imucf_pkg::W_GYRO);
          ba_q[0] <= 44'(roll_a_q) * 44'(imucf_pkg::W_ACC);
          ba_q[1] <= 44'(pitch_a_q) * 44'(imucf_pkg::W_ACC);
          st_q    <= ST_FIN;
        end
        ST_FIN: begin
          att_q[0]    <= imucf_pkg::sat32(64'(bs0 >>> 16));
          att_q[1]    <= imucf_pkg::sat32(64'(bs1 >>> 16));
          att_q[2]    <= imucf_pkg::sat32(64'(yg_q));
          att_q[3]    <= c_q[3];
          att_q[4]    <= c_q[4];
          att_q[5]    <= c_q[5];
          out_valid_q <= 1'b1;
          st_q        <= ST_IDLE;
        end
        ST_DIV_LOAD: begin
          dvd_q  <= acc_mag;
          neg_q  <= acc_q[k_q][47];
          rem_q  <= '0;
          dcnt_q <= '0;
          st_q   <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          rem_q  <= qbit ? 13'(rem2 - {1'b0, cnt_q}) : rem2[12:0];
          dvd_q  <= {dvd_q[46:0], qbit};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd47) begin
            st_q <= ST_DIV_STORE;
          end
        end
        ST_DIV_STORE: begin
          off_q[k_q] <= off_new;
          if (k_q == 3'd5) begin
            cal_ing_q   <= 1'b0;
            cal_ed_q    <= 1'b1;
            calres_q    <= 1'b1;
            out_valid_q <= 1'b1;
            st_q        <= ST_IDLE;
          end else begin
            k_q  <= k_q + 3'd1;
            st_q <= ST_DIV_LOAD;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/imu_complementary_attitude_filter_top.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top
// complementary attitude filter: gyro integration blended with accel angles
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Requests are taken into a two-entry
// queue and executed one at a time by a sequencer. A filter update is bounded by
// the 32-step square root followed by the second cordic pass; start, reset and
// ordinary calibration samples are finished from the idle state. The sample that
// completes calibration runs six serial 48-step divisions. No clearing pass
// after reset.
module imu_complementary_attitude_filter_top #(
  parameter int CORDIC_ITERATIONS = imucf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] accel_x_i,
  input  logic signed [31:0] accel_y_i,
  input  logic signed [31:0] accel_z_i,
  input  logic signed [31:0] gyro_x_i,
  input  logic signed [31:0] gyro_y_i,
  input  logic signed [31:0] gyro_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] roll_angle_o,
  output logic signed [31:0] pitch_angle_o,
  output logic signed [31:0] yaw_angle_o,
  output logic signed [31:0] roll_omega_o,
  output logic signed [31:0] pitch_omega_o,
  output logic signed [31:0] yaw_omega_o,
  output logic        calib_result_o,
  output logic        calibrated_o,
  output logic        calibrating_o
);

  imucf_pkg::cfg_t  cfg_q;
  imucf_pkg::item_t item;
  imucf_pkg::res_t  res;
  logic             item_valid, item_pop;
  logic [5:0][31:0] rd;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calib_ms <= imucf_pkg::CALIB_MS_RESET;
      cfg_q.period   <= imucf_pkg::PERIOD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        imucf_pkg::CFG_CALIB_MS: cfg_q.calib_ms <= cfg_data_i[15:0];
        imucf_pkg::CFG_PERIOD:   cfg_q.period   <= cfg_data_i;
        default:                 cfg_q          <= cfg_q;
      endcase
    end
  end

  assign rd = {gyro_z_i, gyro_y_i, gyro_x_i, accel_z_i, accel_y_i, accel_x_i};

  imucf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rd_i         (rd),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  imucf_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  // result fields
  assign roll_angle_o   = res.att[0];
  assign pitch_angle_o  = res.att[1];
  assign yaw_angle_o    = res.att[2];
  assign roll_omega_o   = res.att[3];
  assign pitch_omega_o  = res.att[4];
  assign yaw_omega_o    = res.att[5];
  assign calib_result_o = res.calib_result;
  assign calibrated_o   = res.calibrated;
  assign calibrating_o  = res.calibrating;

endmodule

// File: hdl/imucf_checker.sv
// ----------------------------------------------------------------------------
// imucf_checker
// port-level checks of the attitude filter, bound to the top level
// ----------------------------------------------------------------------------
`include "imu_complementary_attitude_filter_top_assert.svh"

module imucf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic calib_result_o,
  input logic calibrated_o,
  input logic calibrating_o
);

  // collecting and calibrated are exclusive
  `IMUCF_ASSERT_NOW(a_flags_excl, clk_i, rst_ni, out_valid_o, !(calibrated_o && calibrating_o), "calibrating and calibrated both set")

  // a positive sample outcome means offsets exist
  `IMUCF_ASSERT_NOW(a_result_calib, clk_i, rst_ni, out_valid_o && calib_result_o, calibrated_o, "calib_result without calibrated")

  // a stalled result stays offered
  `IMUCF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

endmodule

bind imu_complementary_attitude_filter_top imucf_checker u_imucf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .calib_result_o (calib_result_o),
  .calibrated_o   (calibrated_o),
  .calibrating_o  (calibrating_o)
);
